### rtl/overlay_tile_snapshot_tracker_assert.svh
// Assertion macros used by the tracker top level.
`ifndef OVERLAY_TILE_SNAPSHOT_TRACKER_ASSERT_SVH
`define OVERLAY_TILE_SNAPSHOT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define OTST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OTST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTST_ASSERT(label, prop, msg)
`define OTST_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/otst_pkg.sv
// Shared constants and types of the overlay tile snapshot tracker.
`timescale 1ns / 1ps
`default_nettype none
package otst_pkg;
  localparam int TILE_SLOTS     = 512;
  localparam int SNAPSHOT_SLOTS = 64;
  localparam int COLUMN_STRIDE  = 16;
  localparam int MAX_COLUMN     = 31;

  localparam int TILE_AW    = $clog2(TILE_SLOTS);
  localparam int IDX_W      = $clog2(TILE_SLOTS + 1);
  localparam int SLOT_W     = 8;
  localparam int SLOT_IDX_W = (SNAPSHOT_SLOTS > 1) ? $clog2(SNAPSHOT_SLOTS) : 1;
  localparam int USED_W     = $clog2(SNAPSHOT_SLOTS + 1);
  localparam int SNAP_AW    = SLOT_IDX_W + 2;
  localparam int SNAP_DEPTH = SNAPSHOT_SLOTS * 4;

  localparam logic [SLOT_W-1:0] NO_SLOT = 8'hFF;

  typedef enum logic [2:0] {
    OP_CLEAR_ALL = 3'd0,
    OP_BASE      = 3'd1,
    OP_BEGIN     = 3'd2,
    OP_FINISH    = 3'd3,
    OP_MARK      = 3'd4,
    OP_RESTORE   = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [TILE_AW-1:0] waddr;
    logic               cur_we;
    logic               cur_wd;
    logic               prev_we;
    logic               prev_wd;
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_wd;
  } tt_wr_t;

  typedef struct packed {
    logic              cur;
    logic              prev;
    logic [SLOT_W-1:0] slot;
  } tt_rd_t;
endpackage
`default_nettype wire

### rtl/otst_tile_table.sv
// Per-tile tables: current mark, previous mark and slot number.
`timescale 1ns / 1ps
`default_nettype none
module otst_tile_table (
  input  wire logic                        clk,
  input  wire otst_pkg::tt_wr_t            wr,
  input  wire logic [otst_pkg::TILE_AW-1:0] raddr,
  output otst_pkg::tt_rd_t                 rd
);
  logic                        cur_mem  [otst_pkg::TILE_SLOTS];
  logic                        prev_mem [otst_pkg::TILE_SLOTS];
  logic [otst_pkg::SLOT_W-1:0] slot_mem [otst_pkg::TILE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.cur_we) begin
      cur_mem[wr.waddr] <= wr.cur_wd;
    end
    if (wr.prev_we) begin
      prev_mem[wr.waddr] <= wr.prev_wd;
    end
    if (wr.slot_we) begin
      slot_mem[wr.waddr] <= wr.slot_wd;
    end
    rd.cur  <= cur_mem[raddr];
    rd.prev <= prev_mem[raddr];
    rd.slot <= slot_mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/otst_snap_ram.sv
// Snapshot row store, one 64-bit word per two rows.
`timescale 1ns / 1ps
`default_nettype none
module otst_snap_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [otst_pkg::SNAP_AW-1:0] waddr,
  input  wire logic [63:0]                  wdata,
  input  wire logic [otst_pkg::SNAP_AW-1:0] raddr,
  output logic [63:0]                       rdata
);
  logic [63:0] mem [otst_pkg::SNAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/overlay_tile_snapshot_tracker.sv
// Top level of the overlay tile snapshot tracker.
`timescale 1ns / 1ps
`default_nettype none
`include "overlay_tile_snapshot_tracker_assert.svh"
// Tracks the tiles an overlay touched in this frame and the last one, and
// keeps a pristine snapshot of each newly touched tile that holds no slot
// yet, while a snapshot slot is free. One command beat is taken at a time;
// s_axis_tready is high only while the sequencer idles. After reset the
// block runs a clearing pass over the tile tables before it takes the first
// beat. Work per command: mark reads the tile tables, then checks and
// updates the tile, and when a snapshot is saved writes the store once per
// row pair; clear all, base rebuilt and begin frame sweep the tile tables;
// finish frame copies current to previous marks through the table port;
// restore walks tiles_in_use tiles (at most TILE_SLOTS), reads four store
// words for each restored tile and stages it. Each result beat can wait
// while the output register is full.
// Every command yields one result beat except restore, which yields one per
// restored tile, or one empty beat when none is restored; tlast marks the
// final one. A finished result waits in the output register while the next
// command is accepted.
module overlay_tile_snapshot_tracker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [9:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[2:0], tile_num[11:3], rows_01[75:12], rows_23[139:76],
  // rows_45[203:140], rows_67[267:204], zero pad above
  input  wire logic [271:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tile_valid[0], out_tile[9:1], out_rows_01[73:10], out_rows_23[137:74],
  // out_rows_45[201:138], out_rows_67[265:202], rebuild_needed[266],
  // previous_columns[298:267], zero pad above
  output logic [303:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SWEEP, ST_MK_RD, ST_MK_CHK, ST_MK_WR,
    ST_RS_RD, ST_RS_CHK, ST_RS_SN, ST_RS_SC, ST_RS_PUT, ST_EMIT
  } state_t;

  state_t state, ret_state;

  // command beat
  logic [2:0]  op;
  logic [8:0]  tile;
  logic [63:0] rows [4];

  // sequencer
  logic [otst_pkg::IDX_W-1:0]      idx;
  logic [otst_pkg::IDX_W-1:0]      lim;
  logic [otst_pkg::TILE_AW-1:0]    idx_d;
  logic                            wr_pend;
  logic [1:0]                      k;
  logic [otst_pkg::SLOT_IDX_W-1:0] slot;
  logic                            emit_last;

  // tracker state
  logic [otst_pkg::USED_W-1:0] slots_used;
  logic                        overflow_flag;
  logic [31:0]                 current_columns;
  logic [31:0]                 last_columns;
  logic [9:0]                  tiles_in_use;

  // staged result and restore gather
  logic        stg_have;
  logic [8:0]  stg_tile;
  logic [63:0] stg_rows [4];
  logic [63:0] new_rows [4];

  // output register
  logic        out_valid;
  logic        out_tile_valid;
  logic [8:0]  out_tile;
  logic [63:0] out_rows [4];
  logic        out_last;
  logic        out_rebuild;
  logic [31:0] out_prev_cols;

  otst_pkg::tt_wr_t              tt_wr;
  otst_pkg::tt_rd_t              tt_rd;
  logic [otst_pkg::TILE_AW-1:0]  tt_raddr;
  logic                          sn_we;
  logic [otst_pkg::SNAP_AW-1:0]  sn_waddr;
  logic [otst_pkg::SNAP_AW-1:0]  sn_raddr;
  logic [63:0]                   sn_rdata;

  logic       idx_lt;
  logic       in_acc;
  logic       tile_ok;
  logic [31:0] col;
  logic       out_free;

  assign idx_lt   = idx < otst_pkg::IDX_W'(otst_pkg::TILE_SLOTS);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign tile_ok  = 32'(tile) < otst_pkg::TILE_SLOTS;
  assign col      = 32'(tile) / otst_pkg::COLUMN_STRIDE;
  assign out_free = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {5'd0, out_prev_cols, out_rebuild, out_rows[3], out_rows[2],
                          out_rows[1], out_rows[0], out_tile, out_tile_valid};

  // Drive the table and store ports from the sequencer state.
  always_comb begin
    tt_wr    = '0;
    tt_raddr = otst_pkg::TILE_AW'(idx);
    sn_we    = 1'b0;
    sn_waddr = {slot, k};
    sn_raddr = {slot, k};
    case (state)
      ST_INIT: begin
        tt_wr.waddr   = otst_pkg::TILE_AW'(idx);
        tt_wr.cur_we  = idx_lt;
        tt_wr.prev_we = idx_lt;
        tt_wr.slot_we = idx_lt;
        tt_wr.slot_wd = otst_pkg::NO_SLOT;
      end
      ST_SWEEP: begin
        tt_wr.waddr   = otst_pkg::TILE_AW'(idx);
        tt_wr.slot_wd = otst_pkg::NO_SLOT;
        case (op)
          otst_pkg::OP_CLEAR_ALL: begin
            tt_wr.cur_we  = idx_lt;
            tt_wr.prev_we = idx_lt;
            tt_wr.slot_we = idx_lt;
          end
          otst_pkg::OP_BASE: begin
            tt_wr.prev_we = idx_lt;
            tt_wr.slot_we = idx_lt;
          end
          otst_pkg::OP_BEGIN: begin
            tt_wr.cur_we = idx_lt;
          end
          default: begin
            // finish frame: copy current marks one entry behind the read
            tt_wr.waddr   = idx_d;
            tt_wr.prev_we = wr_pend;
            tt_wr.prev_wd = tt_rd.cur;
          end
        endcase
      end
      ST_MK_RD: begin
        tt_raddr = otst_pkg::TILE_AW'(tile);
      end
      ST_MK_CHK: begin
        tt_wr.waddr  = otst_pkg::TILE_AW'(tile);
        tt_wr.cur_we = !tt_rd.cur;
        tt_wr.cur_wd = 1'b1;
        tt_wr.slot_we = !tt_rd.cur && (tt_rd.slot == otst_pkg::NO_SLOT) &&
                        (32'(slots_used) < otst_pkg::SNAPSHOT_SLOTS);
        tt_wr.slot_wd = otst_pkg::SLOT_W'(slots_used);
      end
      ST_MK_WR: begin
        sn_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  otst_tile_table u_tile_table (
    .clk   (clk),
    .wr    (tt_wr),
    .raddr (tt_raddr),
    .rd    (tt_rd)
  );

  otst_snap_ram u_snap_ram (
    .clk   (clk),
    .we    (sn_we),
    .waddr (sn_waddr),
    .wdata (rows[k]),
    .raddr (sn_raddr),
    .rdata (sn_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_INIT;
      ret_state       <= ST_IDLE;
      idx             <= '0;
      wr_pend         <= 1'b0;
      slots_used      <= '0;
      overflow_flag   <= 1'b0;
      current_columns <= '0;
      last_columns    <= '0;
      tiles_in_use    <= 10'd512;
      stg_have        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        tiles_in_use <= cfg_wdata;
      end
      // drop the sent beat unless the emit state refills the register
      if (out_valid && m_axis_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (idx_lt) begin
            idx <= idx + 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            op        <= s_axis_tdata[2:0];
            tile      <= s_axis_tdata[11:3];
            rows[0]   <= s_axis_tdata[75:12];
            rows[1]   <= s_axis_tdata[139:76];
            rows[2]   <= s_axis_tdata[203:140];
            rows[3]   <= s_axis_tdata[267:204];
            stg_have  <= 1'b0;
            idx       <= '0;
            wr_pend   <= 1'b0;
            emit_last <= 1'b1;
            ret_state <= ST_IDLE;
            case (s_axis_tdata[2:0])
              otst_pkg::OP_CLEAR_ALL: begin
                current_columns <= '0;
                last_columns    <= '0;
                slots_used      <= '0;
                overflow_flag   <= 1'b0;
                state           <= ST_SWEEP;
              end
              otst_pkg::OP_BASE: begin
                slots_used    <= '0;
                overflow_flag <= 1'b0;
                state         <= ST_SWEEP;
              end
              otst_pkg::OP_BEGIN: begin
                current_columns <= '0;
                state           <= ST_SWEEP;
              end
              otst_pkg::OP_FINISH: begin
                state <= ST_SWEEP;
              end
              otst_pkg::OP_MARK: begin
                state <= ST_MK_RD;
              end
              otst_pkg::OP_RESTORE: begin
                // clamp the walk to the table size
                lim   <= (32'(tiles_in_use) > otst_pkg::TILE_SLOTS) ?
                         otst_pkg::IDX_W'(otst_pkg::TILE_SLOTS) :
                         otst_pkg::IDX_W'(tiles_in_use);
                state <= ST_RS_RD;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (op == otst_pkg::OP_FINISH) begin
            wr_pend <= idx_lt;
            idx_d   <= otst_pkg::TILE_AW'(idx);
            if (idx_lt) begin
              idx <= idx + 1'b1;
            end else if (!wr_pend) begin
              last_columns <= current_columns;
              state        <= ST_EMIT;
            end
          end else if (idx_lt) begin
            idx <= idx + 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_MK_RD: begin
          // out-of-range tiles drop straight to an empty result
          state <= tile_ok ? ST_MK_CHK : ST_EMIT;
        end
        ST_MK_CHK: begin
          if (!tt_rd.cur) begin
            if (col <= otst_pkg::MAX_COLUMN) begin
              current_columns[col[4:0]] <= 1'b1;
            end
            stg_have <= 1'b1;
            stg_tile <= tile;
            for (int i = 0; i < 4; i++) begin
              stg_rows[i] <= '0;
            end
            if (tt_rd.slot == otst_pkg::NO_SLOT) begin
              if (32'(slots_used) >= otst_pkg::SNAPSHOT_SLOTS) begin
                overflow_flag <= 1'b1;
                state         <= ST_EMIT;
              end else begin
                slot       <= slots_used[otst_pkg::SLOT_IDX_W-1:0];
                slots_used <= slots_used + 1'b1;
                k          <= 2'd0;
                state      <= ST_MK_WR;
              end
            end else begin
              state <= ST_EMIT;
            end
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_MK_WR: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= ST_EMIT;
          end
        end
        ST_RS_RD: begin
          if (idx >= lim) begin
            emit_last <= 1'b1;
            ret_state <= ST_IDLE;
            state     <= ST_EMIT;
          end else begin
            state <= ST_RS_CHK;
          end
        end
        ST_RS_CHK: begin
          if (tt_rd.prev && (tt_rd.slot != otst_pkg::NO_SLOT) &&
              (32'(tt_rd.slot) < otst_pkg::SNAPSHOT_SLOTS)) begin
            slot  <= tt_rd.slot[otst_pkg::SLOT_IDX_W-1:0];
            k     <= 2'd0;
            state <= ST_RS_SN;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_RS_RD;
          end
        end
        ST_RS_SN: begin
          state <= ST_RS_SC;
        end
        ST_RS_SC: begin
          new_rows[k] <= sn_rdata;
          if (k == 2'd3) begin
            // release the previously found tile before staging this one
            if (stg_have) begin
              emit_last <= 1'b0;
              ret_state <= ST_RS_PUT;
              state     <= ST_EMIT;
            end else begin
              state <= ST_RS_PUT;
            end
          end else begin
            k     <= k + 2'd1;
            state <= ST_RS_SN;
          end
        end
        ST_RS_PUT: begin
          stg_have <= 1'b1;
          stg_tile <= 9'(idx);
          for (int i = 0; i < 4; i++) begin
            stg_rows[i] <= new_rows[i];
          end
          idx   <= idx + 1'b1;
          state <= ST_RS_RD;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_tile_valid <= stg_have;
            out_tile       <= stg_have ? stg_tile : 9'd0;
            for (int i = 0; i < 4; i++) begin
              out_rows[i] <= stg_have ? stg_rows[i] : 64'd0;
            end
            out_last      <= emit_last;
            out_rebuild   <= overflow_flag;
            out_prev_cols <= last_columns;
            state         <= ret_state;
          end else if (out_valid && m_axis_tready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `OTST_ASSERT(a_pool_bound, 32'(slots_used) <= otst_pkg::SNAPSHOT_SLOTS, "slot pool count out of range")
  `OTST_ASSERT(a_ovf_full, $rose(overflow_flag) |-> 32'(slots_used) == otst_pkg::SNAPSHOT_SLOTS, "rebuild flag set while pool not full")
  `OTST_ASSERT(a_empty_beat, m_axis_tvalid && !out_tile_valid |-> out_tile == 9'd0 && out_rows[0] == 64'd0 && out_rows[3] == 64'd0, "empty result carries data")
  `OTST_ASSERT(a_store_wr, sn_we |-> state == ST_MK_WR && slots_used != '0, "store written outside a snapshot save")
endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the overlay tile snapshot tracker.
`timescale 1ns / 1ps
module tb;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [63:0] r67, r45, r23, r01;
  } rows_t;

  typedef struct {
    logic        valid;
    logic [8:0]  tile;
    rows_t       rows;
    logic        last;
    logic        rebuild;
    logic [31:0] prev_cols;
  } tile_result_t;

  typedef struct {
    logic [2:0] op;
    logic [8:0] tile;
    rows_t      rows;
    logic       chk;     // typed-in expectation present
    logic       e_valid;
    logic       e_rebuild;
  } cmd_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [9:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [271:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [303:0] m_axis_tdata;
  logic         m_axis_tlast;

  overlay_tile_snapshot_tracker u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the tracker
  logic        cur_mark [otst_pkg::TILE_SLOTS];
  logic        prev_mark [otst_pkg::TILE_SLOTS];
  logic [7:0]  tile_slot [otst_pkg::TILE_SLOTS];
  rows_t       snap [otst_pkg::SNAPSHOT_SLOTS];
  int unsigned slots_taken;
  logic        overflow;
  logic [31:0] cur_cols, last_cols;
  logic [9:0]  walk_limit;

  tile_result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_restored = 0;
  bit stim_done = 0;

  function automatic void drop_slots();
    for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) tile_slot[t] = otst_pkg::NO_SLOT;
    slots_taken = 0;
    overflow = 1'b0;
  endfunction

  function automatic void push_result(logic v, logic [8:0] t, rows_t r);
    tile_result_t e;
    e.valid = v; e.tile = v ? t : 9'd0; e.rows = r; e.last = 1'b0;
    e.rebuild = overflow; e.prev_cols = last_cols;
    expected_q.push_back(e);
  endfunction

  // Apply one command to the shadow state and queue the beats it yields
  function automatic void predict_tracker(logic [2:0] op, logic [8:0] tile, rows_t rows);
    int n = 0;
    int lim;
    int col;
    case (op)
      otst_pkg::OP_CLEAR_ALL: begin
        for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) begin
          cur_mark[t] = 1'b0; prev_mark[t] = 1'b0;
        end
        cur_cols = '0; last_cols = '0;
        drop_slots();
      end
      otst_pkg::OP_BASE: begin
        for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) prev_mark[t] = 1'b0;
        drop_slots();
      end
      otst_pkg::OP_BEGIN: begin
        for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) cur_mark[t] = 1'b0;
        cur_cols = '0;
      end
      otst_pkg::OP_FINISH: begin
        for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) prev_mark[t] = cur_mark[t];
        last_cols = cur_cols;
      end
      otst_pkg::OP_MARK: begin
        if (!cur_mark[tile]) begin
          col = tile / otst_pkg::COLUMN_STRIDE;
          if (col <= otst_pkg::MAX_COLUMN) cur_cols[col] = 1'b1;
          if (tile_slot[tile] == otst_pkg::NO_SLOT) begin
            if (slots_taken >= otst_pkg::SNAPSHOT_SLOTS) overflow = 1'b1;
            else begin
              tile_slot[tile] = slots_taken[7:0];
              snap[slots_taken] = rows;
              slots_taken++;
            end
          end
          cur_mark[tile] = 1'b1;
          push_result(1'b1, tile, '0);
          n++;
        end
      end
      otst_pkg::OP_RESTORE: begin
        lim = (walk_limit > otst_pkg::TILE_SLOTS) ? otst_pkg::TILE_SLOTS : walk_limit;
        for (int t = 0; t < lim; t++) begin
          if (prev_mark[t] && tile_slot[t] != otst_pkg::NO_SLOT &&
              tile_slot[t] < otst_pkg::SNAPSHOT_SLOTS && n < otst_pkg::SNAPSHOT_SLOTS) begin
            push_result(1'b1, t[8:0], snap[tile_slot[t]]);
            n++;
            n_restored++;
          end
        end
      end
      default: ;
    endcase
    if (n == 0) push_result(1'b0, 9'd0, '0);
    expected_q[$].last = 1'b1;
  endfunction

  // Output side: random stall per beat, compare against the oldest expectation
  initial begin
    tile_result_t e;
    tile_result_t got;
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got.valid = m_axis_tdata[0];
      got.tile = m_axis_tdata[9:1];
      got.rows = {m_axis_tdata[265:202], m_axis_tdata[201:138],
                  m_axis_tdata[137:74], m_axis_tdata[73:10]};
      got.rebuild = m_axis_tdata[266];
      got.prev_cols = m_axis_tdata[298:267];
      got.last = m_axis_tlast;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat valid=%0d tile=%0d", $realtime, got.valid, got.tile);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (got.valid !== e.valid || got.tile !== e.tile || got.rows !== e.rows ||
            got.last !== e.last || got.rebuild !== e.rebuild ||
            got.prev_cols !== e.prev_cols || m_axis_tdata[303:299] !== '0) begin
          $display("%0t: mismatch exp v=%0d t=%0d rows=%h l=%0d rb=%0d pc=%h", $realtime,
                   e.valid, e.tile, e.rows, e.last, e.rebuild, e.prev_cols);
          $display("%0t:          got v=%0d t=%0d rows=%h l=%0d rb=%0d pc=%h", $realtime,
                   got.valid, got.tile, got.rows, got.last, got.rebuild, got.prev_cols);
          errors++;
        end
      end
    end
  end

  // Send one command beat after a random gap, predicting on acceptance
  task automatic send_cmd(logic [2:0] op, logic [8:0] tile, rows_t rows);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {4'b0, rows.r67, rows.r45, rows.r23, rows.r01, tile, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_tracker(op, tile, rows);
  endtask

  // Drain outstanding beats, let the sequencer settle, then write the register
  task automatic set_walk_limit(logic [9:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    walk_limit = v;
  endtask

  function automatic rows_t rand_rows();
    rows_t r;
    for (int i = 0; i < 8; i++) r[i*32 +: 32] = $urandom;
    return r;
  endfunction

  initial begin
    cmd_row_t dir[$];
    cmd_row_t c;
    tile_result_t e;
    int r;
    logic [2:0] op;
    logic [8:0] tl;
    for (int t = 0; t < otst_pkg::TILE_SLOTS; t++) begin
      cur_mark[t] = 1'b0; prev_mark[t] = 1'b0;
    end
    cur_cols = '0; last_cols = '0; walk_limit = 10'd512;
    drop_slots();

    // Directed table: chk rows carry an expectation readable at a glance
    dir.push_back('{otst_pkg::OP_RESTORE, 9'd0, '0, 1'b1, 1'b0, 1'b0}); // empty after reset
    dir.push_back('{OP_SPARE_6, 9'd0, '0, 1'b1, 1'b0, 1'b0});           // unused opcode
    dir.push_back('{OP_SPARE_7, 9'd511, '0, 1'b1, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_BEGIN, 9'd0, '0, 1'b1, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_MARK, 9'd0, '1, 1'b1, 1'b1, 1'b0});    // all ones rows
    dir.push_back('{otst_pkg::OP_MARK, 9'd511, '0, 1'b1, 1'b1, 1'b0});  // top tile, column 31
    dir.push_back('{otst_pkg::OP_MARK, 9'd0, '1, 1'b1, 1'b0, 1'b0});    // repeat mark
    dir.push_back('{otst_pkg::OP_MARK, 9'd37, rand_rows(), 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_MARK, 9'd256, rand_rows(), 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_FINISH, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_RESTORE, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_BEGIN, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    // tile 37 already has a slot
    dir.push_back('{otst_pkg::OP_MARK, 9'd37, rand_rows(), 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_RESTORE, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_BASE, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_RESTORE, 9'd0, '0, 1'b0, 1'b0, 1'b0});
    dir.push_back('{otst_pkg::OP_CLEAR_ALL, 9'd0, '0, 1'b1, 1'b0, 1'b0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir[i]) begin
      c = dir[i];
      send_cmd(c.op, c.tile, c.rows);
      if (c.chk) begin
        // every checked row yields a single beat, the newest expectation
        e = expected_q[$];
        if (e.valid !== c.e_valid || e.rebuild !== c.e_rebuild) begin
          $display("%0t: table row %0d exp v=%0d rb=%0d, predicted v=%0d rb=%0d",
                   $realtime, i, c.e_valid, c.e_rebuild, e.valid, e.rebuild);
          errors++;
        end
      end
    end

    // Pool overflow: 70 distinct tiles, then restore everything
    send_cmd(otst_pkg::OP_BEGIN, 9'd0, '0);
    for (int t = 0; t < 70; t++) send_cmd(otst_pkg::OP_MARK, 9'(t * 7), rand_rows());
    send_cmd(otst_pkg::OP_FINISH, 9'd0, '0);
    send_cmd(otst_pkg::OP_RESTORE, 9'd0, '0);
    set_walk_limit(10'd0);
    send_cmd(otst_pkg::OP_RESTORE, 9'd0, '0);
    set_walk_limit(10'd1023);
    send_cmd(otst_pkg::OP_RESTORE, 9'd0, '0);
    send_cmd(otst_pkg::OP_CLEAR_ALL, 9'd0, '0);

    // Random frames with a walk limit change between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_walk_limit(10'd511);
        1: set_walk_limit(10'd1);
        2: set_walk_limit(10'($urandom_range(0, 1023)));
        default: set_walk_limit(10'd512);
      endcase
      for (int it = 0; it < 30; it++) begin
        r = $urandom_range(0, 99);
        tl = (r < 60) ? 9'($urandom_range(0, 63)) : 9'($urandom_range(0, 511));
        if (r < 55) op = otst_pkg::OP_MARK;
        else if (r < 65) op = otst_pkg::OP_FINISH;
        else if (r < 75) op = otst_pkg::OP_RESTORE;
        else if (r < 84) op = otst_pkg::OP_BEGIN;
        else if (r < 90) op = otst_pkg::OP_BASE;
        else if (r < 94) op = otst_pkg::OP_CLEAR_ALL;
        else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        send_cmd(op, tl, rand_rows());
      end
      send_cmd(otst_pkg::OP_FINISH, 9'd0, '0);
      send_cmd(otst_pkg::OP_RESTORE, 9'd0, '0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d result beats, %0d restored tiles, all opcodes and walk limits.",
             n_results, n_restored);
    if (errors == 0 && expected_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats outstanding", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/otst_pkg.sv
rtl/otst_tile_table.sv
rtl/otst_snap_ram.sv
rtl/overlay_tile_snapshot_tracker.sv
test/tb.sv
